// File: design/multi_pattern_anchored_matcher_macros.svh
// Assertion macros used by the matcher top-level RTL file.
`ifndef MULTI_PATTERN_ANCHORED_MATCHER_MACROS_SVH
`define MULTI_PATTERN_ANCHORED_MATCHER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define MPAM_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("matcher check failed");

// Next-cycle implication, sampled on i_clk, off during reset
`define MPAM_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("matcher check failed");

`endif

// File: design/mpam_pkg.sv
// Package: types, constants and helper functions of the anchored pattern matcher.
package mpam_pkg;

    localparam int MAX_PATTERNS = 64;
    localparam int MAX_LENGTH   = 16;
    localparam int POS_W        = $clog2(MAX_LENGTH);
    localparam int ADDR_W       = POS_W + 8;

    localparam logic [63:0] PATTERN_MASK = (MAX_PATTERNS >= 64) ? {64{1'b1}} :
        ((64'd1 << (MAX_PATTERNS % 64)) - 64'd1);

    // item codes
    typedef enum logic [1:0] {
        OP_LOAD_ACCEPT = 2'd0,
        OP_LOAD_END    = 2'd1,
        OP_MATCH       = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_NO_MATCH = 2'd0,
        ST_MATCHED  = 2'd1,
        ST_SHORT    = 2'd2
    } t_status;

    // configuration register indexes
    localparam logic [1:0] CFG_FOLD_CASE      = 2'd0;
    localparam logic [1:0] CFG_PATTERN_LENGTH = 2'd1;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  position;
        logic [7:0]  byte_value;
        logic [63:0] mask;
        logic        last_byte;
    } t_in_req;

    typedef struct packed {
        t_status     status;
        logic [4:0]  match_length;
        logic [5:0]  winner;
    } t_out_req;

    // match byte handed from the lookup stage to the evaluator
    typedef struct packed {
        logic [4:0] pos;
        logic       last;
    } t_stage;

    // evaluator result toward the output register
    typedef struct packed {
        logic     emit;
        t_out_req res;
    } t_eval;

    // clamp the configured length to 1..MAX_LENGTH
    function automatic logic [4:0] effective_length(input logic [4:0] len);
        logic [4:0] l;
        l = len;
        if (l == 5'd0) l = 5'd1;
        if (int'(l) > MAX_LENGTH) l = 5'(MAX_LENGTH);
        return l;
    endfunction

    // index of the lowest set bit: isolate it, then encode
    function automatic logic [5:0] lowest_index(input logic [63:0] m);
        logic [63:0] one;
        logic [5:0]  idx;
        one = m & (~m + 64'd1);
        idx = '0;
        for (int i = 0; i < 64; i++) begin
            if (one[i]) idx = idx | 6'(i);
        end
        return idx;
    endfunction

endpackage

// File: design/multi_pattern_anchored_matcher.sv
// Top level of the anchored multi-pattern matcher: table memory, lookup stage, output register.
//
// Usage:
//   Input channel (i_valid / o_stall, payload i_data) carries three kinds of
//   request: accept-mask loads, end-mask loads and subject bytes. Loads write
//   the per-position tables and give no result. Subject bytes are matched one
//   per cycle, while o_stall is low, against all patterns at once.
//   Output channel (o_valid / i_stall, payload o_data) carries at most one
//   result per subject byte: no match, matched (length and pattern index), or
//   subject too short to decide.
//   A subject byte, once accepted, has its accept-table word read into a
//   register, is evaluated in the following cycle and its result is written
//   to the output register when the evaluator advances. One request is taken
//   per cycle while o_stall is low.
//   The configuration port (i_cfg_we / i_cfg_index / i_cfg_data) sets case
//   folding and the pattern length; write it only while the block is idle.
//   Reset restores the subject state and configuration; the tables keep
//   their contents and must be loaded before use.
//   When the receiver stalls, the result waits in the output register; bytes
//   that give no result flow on, and o_stall rises once the evaluator holds a result.
module multi_pattern_anchored_matcher (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  mpam_pkg::t_in_req  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output mpam_pkg::t_out_req o_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [4:0]         i_cfg_data
);
    import mpam_pkg::*;

    `include "multi_pattern_anchored_matcher_macros.svh"

    // configuration
    logic       r_fold_case;
    logic [4:0] r_pattern_length;
    logic [4:0] limit;

    // lookup stage
    logic [4:0]  r_rd_pos;
    logic [4:0]  rd_pos;
    logic [7:0]  ch;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic        accept, is_match, is_load_acc, is_load_end, pos_ok;

    logic [63:0] r_mem [MAX_LENGTH*256];
    logic [63:0] r_end_masks [MAX_LENGTH];
    logic [63:0] r_accept;

    logic        r_s1_valid;
    t_stage      r_s1;
    t_eval       ev;
    logic        out_free, adv;

    logic        r_out_valid;
    t_out_req    r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_case      <= 1'b0;
            r_pattern_length <= 5'd16;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_FOLD_CASE) r_fold_case <= i_cfg_data[0];
            if (i_cfg_index == CFG_PATTERN_LENGTH) r_pattern_length <= i_cfg_data;
        end
    end

    assign limit = effective_length(r_pattern_length);

    // handshake: stall only when a result cannot leave the evaluator
    assign out_free = !r_out_valid || !i_stall;
    assign adv      = r_s1_valid && (!ev.emit || out_free);
    assign o_stall  = r_s1_valid && !adv;
    assign accept   = i_valid && !o_stall;

    assign is_match    = accept && (i_data.op == OP_MATCH);
    assign is_load_acc = accept && (i_data.op == OP_LOAD_ACCEPT);
    assign is_load_end = accept && (i_data.op == OP_LOAD_END);
    assign pos_ok      = int'(i_data.position) < MAX_LENGTH;

    // lookup address: folded byte at the clamped subject position
    always_comb begin
        ch = i_data.byte_value;
        if (r_fold_case && ch >= 8'h41 && ch <= 8'h5a) ch = ch + 8'd32;
        rd_pos  = (r_rd_pos >= limit) ? (limit - 5'd1) : r_rd_pos;
        rd_addr = {POS_W'(rd_pos), ch};
        wr_addr = {POS_W'(i_data.position), i_data.byte_value};
    end

    // predicted subject position for the next lookup
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pos <= '0;
        end else if (is_match) begin
            r_rd_pos <= i_data.last_byte ? 5'd0 : (rd_pos + 5'd1);
        end
    end

    // accept table memory
    always_ff @(posedge i_clk) begin
        if (is_load_acc && pos_ok) r_mem[wr_addr] <= i_data.mask;
    end

    always_ff @(posedge i_clk) begin
        if (is_match) r_accept <= r_mem[rd_addr];
    end

    // end masks, one per position
    always_ff @(posedge i_clk) begin
        if (is_load_end && pos_ok) r_end_masks[POS_W'(i_data.position)] <= i_data.mask;
    end

    // evaluator stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (is_match) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_match) begin
            r_s1.pos  <= rd_pos;
            r_s1.last <= i_data.last_byte;
        end
    end

    mpam_eval u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_stage  (r_s1),
        .i_accept (r_accept),
        .i_end    (r_end_masks[POS_W'(r_s1.pos)]),
        .i_limit  (limit),
        .o_eval   (ev)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && ev.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && ev.emit) r_out <= ev.res;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // checks
    `MPAM_ASSERT_NOW(a_stall_needs_item, o_stall, r_s1_valid && r_out_valid && i_stall)
    `MPAM_ASSERT_NOW(a_fields_zero, o_valid && o_data.status != ST_MATCHED,
        o_data.match_length == 5'd0 && o_data.winner == 6'd0)
    `MPAM_ASSERT_NOW(a_match_len, o_valid && o_data.status == ST_MATCHED,
        o_data.match_length != 5'd0 && int'(o_data.match_length) <= MAX_LENGTH)
    `MPAM_ASSERT_NOW(a_pos_bound, r_s1_valid, r_s1.pos < limit)
    `MPAM_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_data))

endmodule

// File: design/mpam_eval.sv
// Match evaluator: live-pattern state, best end tracking and result decision.
module mpam_eval (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  mpam_pkg::t_stage     i_stage,
    input  logic [63:0]          i_accept,
    input  logic [63:0]          i_end,
    input  logic [4:0]           i_limit,
    output mpam_pkg::t_eval      o_eval
);
    import mpam_pkg::*;

    logic [63:0] r_live, n_live;
    logic [4:0]  r_best_len, n_best_len;
    logic [5:0]  r_best_pat, n_best_pat;
    logic        r_have_best, n_have_best;
    logic        r_decided, n_decided;

    logic [63:0] cur, ends, low_bit;
    logic [4:0]  pos_next;
    logic        emit;
    t_status     status;

    // one subject byte: AND in the lookup, look for ends, decide
    always_comb begin
        cur         = r_live & i_accept & PATTERN_MASK;
        ends        = cur & i_end;
        low_bit     = cur & (~cur + 64'd1);
        pos_next    = i_stage.pos + 5'd1;
        n_live      = r_live;
        n_best_len  = r_best_len;
        n_best_pat  = r_best_pat;
        n_have_best = r_have_best;
        n_decided   = r_decided;
        emit        = 1'b0;
        status      = ST_NO_MATCH;

        if (r_decided) begin
            // skip to the end of the subject
            if (i_stage.last) begin
                n_live      = '1;
                n_best_len  = '0;
                n_best_pat  = '0;
                n_have_best = 1'b0;
                n_decided   = 1'b0;
            end
        end else if (cur == 64'd0) begin
            emit   = 1'b1;
            status = r_have_best ? ST_MATCHED : ST_NO_MATCH;
        end else begin
            if (ends != 64'd0) begin
                n_best_len  = pos_next;
                n_best_pat  = lowest_index(ends);
                n_have_best = 1'b1;
            end
            if ((ends & low_bit) != 64'd0) begin
                // lowest live pattern ends here
                emit   = 1'b1;
                status = ST_MATCHED;
            end else begin
                n_live = cur;
                if (pos_next >= i_limit || i_stage.last) begin
                    emit   = 1'b1;
                    status = n_have_best ? ST_MATCHED : ST_SHORT;
                end
            end
        end

        o_eval.emit             = emit;
        o_eval.res.status       = status;
        o_eval.res.match_length = (status == ST_MATCHED) ? n_best_len : 5'd0;
        o_eval.res.winner       = (status == ST_MATCHED) ? n_best_pat : 6'd0;

        // a result closes the subject or parks until its last byte
        if (emit) begin
            if (i_stage.last) begin
                n_live      = '1;
                n_best_len  = '0;
                n_best_pat  = '0;
                n_have_best = 1'b0;
                n_decided   = 1'b0;
            end else begin
                n_decided   = 1'b1;
            end
        end
    end

    // subject state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= '1;
            r_best_len  <= '0;
            r_best_pat  <= '0;
            r_have_best <= 1'b0;
            r_decided   <= 1'b0;
        end else if (i_adv) begin
            r_live      <= n_live;
            r_best_len  <= n_best_len;
            r_best_pat  <= n_best_pat;
            r_have_best <= n_have_best;
            r_decided   <= n_decided;
        end
    end

endmodule

// File: sim/mpam_checker.sv
`timescale 1ns / 100ps
// Result checker for the anchored matcher: predicts results from observed requests, compares them.
module mpam_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  mpam_pkg::t_in_req  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  mpam_pkg::t_out_req i_out_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [4:0]         i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    import mpam_pkg::*;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] FOLD_OFFSET  = 8'h20;

    // mirrored tables and subject state
    logic [63:0] accept_mem [0:MAX_LENGTH*256-1];
    logic [63:0] end_mem    [0:MAX_LENGTH-1];
    logic [63:0] live_q;
    logic [4:0]  pos_q;
    logic [4:0]  best_len_q;
    logic [5:0]  best_pat_q;
    logic        have_best_q;
    logic        decided_q;
    logic        fold_q;
    logic [4:0]  plen_q;

    t_out_req    expected_results [$];
    t_out_req    want;

    initial o_fail_count = 0;
    initial o_pending    = 0;

    // lowest set bit of a pattern mask, 63 when empty
    function automatic logic [5:0] first_pattern(input logic [63:0] m);
        logic [5:0] idx;
        idx = 6'd63;
        for (int i = 63; i >= 0; i--) begin
            if (m[i]) idx = 6'(i);
        end
        return idx;
    endfunction

    // configured length limited to 1..MAX_LENGTH
    function automatic logic [4:0] clamp_length(input logic [4:0] len);
        if (len == 5'd0) return 5'd1;
        if (len > 5'(MAX_LENGTH)) return 5'(MAX_LENGTH);
        return len;
    endfunction

    task automatic restart_subject();
        live_q      = '1;
        pos_q       = '0;
        best_len_q  = '0;
        best_pat_q  = '0;
        have_best_q = 1'b0;
    endtask

    // apply one request to the mirror and queue the result it causes, if any
    task automatic predict_request(input t_in_req req);
        logic [7:0]  ch;
        logic [4:0]  limit;
        logic [63:0] cur;
        logic [63:0] ends;
        logic        done;
        t_status     st;
        t_out_req    res;
        done = 1'b0;
        st   = ST_NO_MATCH;
        res  = '0;
        case (req.op)
            OP_LOAD_ACCEPT: accept_mem[{req.position, req.byte_value}] = req.mask;
            OP_LOAD_END:    end_mem[req.position] = req.mask;
            OP_MATCH: begin
                if (decided_q) begin
                    // already answered: swallow bytes up to the end of the subject
                    if (req.last_byte) begin
                        restart_subject();
                        decided_q = 1'b0;
                    end
                end else begin
                    ch = req.byte_value;
                    if (fold_q && ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) ch = ch + FOLD_OFFSET;
                    limit = clamp_length(plen_q);
                    if (pos_q >= limit) pos_q = limit - 5'd1;
                    cur = live_q & accept_mem[{pos_q[POS_W-1:0], ch}] & PATTERN_MASK;
                    if (cur == '0) begin
                        done = 1'b1;
                        st   = have_best_q ? ST_MATCHED : ST_NO_MATCH;
                    end else begin
                        ends = cur & end_mem[pos_q[POS_W-1:0]];
                        if (ends != '0) begin
                            best_len_q  = pos_q + 5'd1;
                            best_pat_q  = first_pattern(ends);
                            have_best_q = 1'b1;
                            // lowest live pattern ends here: nothing can beat it
                            if (ends[first_pattern(cur)]) begin
                                done = 1'b1;
                                st   = ST_MATCHED;
                            end
                        end
                        if (!done) begin
                            live_q = cur;
                            pos_q  = pos_q + 5'd1;
                            if (pos_q >= limit || req.last_byte) begin
                                done = 1'b1;
                                st   = have_best_q ? ST_MATCHED : ST_SHORT;
                            end
                        end
                    end
                    if (done) begin
                        res.status = st;
                        if (st == ST_MATCHED) begin
                            res.match_length = best_len_q;
                            res.winner       = best_pat_q;
                        end
                        expected_results.push_back(res);
                        if (req.last_byte) begin
                            restart_subject();
                            decided_q = 1'b0;
                        end else begin
                            decided_q = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // watch both channels and the configuration port
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_subject();
            decided_q = 1'b0;
            fold_q    = 1'b0;
            plen_q    = 5'd16;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    $error("unexpected result: status %0d length %0d pattern %0d",
                           i_out_data.status, i_out_data.match_length, i_out_data.winner);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.status !== want.status ||
                        i_out_data.match_length !== want.match_length ||
                        i_out_data.winner !== want.winner) begin
                        o_fail_count <= o_fail_count + 1;
                    end
                    if (i_out_data.status !== want.status)
                        $error("status: expected %0d, got %0d", want.status, i_out_data.status);
                    if (i_out_data.match_length !== want.match_length)
                        $error("match_length: expected %0d, got %0d",
                               want.match_length, i_out_data.match_length);
                    if (i_out_data.winner !== want.winner)
                        $error("winner: expected %0d, got %0d",
                               want.winner, i_out_data.winner);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FOLD_CASE) fold_q = i_cfg_data[0];
                else if (i_cfg_index == CFG_PATTERN_LENGTH) plen_q = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) predict_request(i_in_data);
        end
        o_pending <= expected_results.size();
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// Testbench top for the anchored matcher: table fill, directed and random requests, verdict.
module tb;

    import mpam_pkg::*;

    localparam logic [1:0] OP_RESERVED   = 2'd3;
    localparam logic [7:0] LOWER_A       = 8'h61;
    localparam logic [7:0] UPPER_A       = 8'h41;
    localparam int         ALPHABET      = 8;
    localparam int         EXTRA_BYTES   = 4;
    localparam int         FILL_BYTES    = 2 * ALPHABET + EXTRA_BYTES;
    localparam int         PHASE_ITEMS   = 95;
    localparam int         PHASES        = 8;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         SETTLE_CYCLES = 6;
    localparam int         CYCLE_LIMIT   = 400000;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_in_req  i_data;
    logic     o_valid;
    logic     i_stall;
    t_out_req o_data;
    logic     i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [4:0] i_cfg_data;

    int fail_count;
    int pending;
    int send_idle   = 0;
    int recv_stall  = 0;
    int hold_left   = 0;
    int cycle_count = 0;

    multi_pattern_anchored_matcher DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    mpam_checker u_result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_data   (o_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver: random stalls, or a long hold-off while hold_left runs down
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // each bit set with probability 3/4
    function automatic logic [63:0] dense_mask();
        return {$urandom | $urandom, $urandom | $urandom};
    endfunction

    // each bit set with probability 1/8
    function automatic logic [63:0] sparse_mask();
        return {$urandom & $urandom & $urandom, $urandom & $urandom & $urandom};
    endfunction

    // alphabet bytes get dense masks so subjects run deep; others are mostly dead
    function automatic logic [63:0] table_mask(input logic [7:0] b);
        if (b >= LOWER_A && b < LOWER_A + ALPHABET) return dense_mask();
        if ($urandom_range(15) == 0) return {$urandom, $urandom};
        return '0;
    endfunction

    // bytes outside the alphabet that subjects may also carry
    function automatic logic [7:0] extra_byte(input int k);
        case (k)
            0: return 8'h00;
            1: return 8'h7A;
            2: return 8'h7F;
            default: return 8'hFF;
        endcase
    endfunction

    // every byte a subject can carry: lower case, upper case, then the extras
    function automatic logic [7:0] fill_byte(input int k);
        if (k < ALPHABET) return LOWER_A + 8'(k);
        if (k < 2 * ALPHABET) return UPPER_A + 8'(k - ALPHABET);
        return extra_byte(k - 2 * ALPHABET);
    endfunction

    function automatic t_in_req make_req(input logic [1:0] op, input logic [3:0] pos,
                                         input logic [7:0] b, input logic [63:0] m,
                                         input logic last);
        t_in_req r;
        r.op         = op;
        r.position   = pos;
        r.byte_value = b;
        r.mask       = m;
        r.last_byte  = last;
        return r;
    endfunction

    function automatic t_in_req random_load();
        logic [7:0] b;
        if ($urandom_range(1) == 0) begin
            b = ($urandom_range(3) != 0) ? LOWER_A + 8'($urandom_range(ALPHABET - 1))
                                         : 8'($urandom_range(255));
            return make_req(OP_LOAD_ACCEPT, 4'($urandom_range(15)), b, table_mask(b),
                            1'($urandom_range(1)));
        end
        return make_req(OP_LOAD_END, 4'($urandom_range(15)), 8'($urandom_range(255)),
                        sparse_mask(), 1'($urandom_range(1)));
    endfunction

    // mostly alphabet, some upper case for folding, some bytes outside it
    function automatic logic [7:0] pick_subject_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80) return LOWER_A + 8'($urandom_range(ALPHABET - 1));
        if (roll < 90) return UPPER_A + 8'($urandom_range(ALPHABET - 1));
        return extra_byte(int'($urandom_range(EXTRA_BYTES - 1)));
    endfunction

    // offer one request, entered and left at a falling edge
    task automatic offer_request(input t_in_req r);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // drop valid and wait until every predicted result has come out
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_config(input logic fold, input logic [4:0] len);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FOLD_CASE;
        i_cfg_data  <= {4'd0, fold};
        @(negedge i_clk);
        i_cfg_index <= CFG_PATTERN_LENGTH;
        i_cfg_data  <= len;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int         count;
        int         n_bytes;
        int         roll;
        bit         paused;
        logic       fold;
        logic [4:0] len;
        logic [7:0] fb;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_config(1'b0, 5'd16);

        // fill every entry a subject byte can reach, at every position
        for (int p = 0; p < MAX_LENGTH; p++) begin
            for (int k = 0; k < FILL_BYTES; k++) begin
                fb = fill_byte(k);
                offer_request(make_req(OP_LOAD_ACCEPT, 4'(p), fb, table_mask(fb), 1'b0));
            end
        end
        for (int p = 0; p < MAX_LENGTH; p++)
            offer_request(make_req(OP_LOAD_END, 4'(p), 8'd0, sparse_mask(), 1'b0));

        // directed: field extremes, a late winner, unused op, early decision
        offer_request(make_req(OP_LOAD_ACCEPT, 4'd0, 8'h7A, '1, 1'b0));
        offer_request(make_req(OP_LOAD_END, 4'd0, 8'd0, 64'h8000_0000_0000_0000, 1'b0));
        offer_request(make_req(OP_MATCH, 4'd0, 8'h7A, '0, 1'b0));
        offer_request(make_req(OP_MATCH, 4'd15, 8'h7A, '1, 1'b1));
        offer_request(make_req(OP_LOAD_END, 4'd0, 8'hFF, sparse_mask(), 1'b1));
        offer_request(make_req(OP_MATCH, 4'd0, 8'h00, '0, 1'b1));
        offer_request(make_req(OP_MATCH, 4'd15, 8'hFF, '1, 1'b1));
        offer_request(make_req(OP_RESERVED, 4'd15, 8'hFF, '1, 1'b1));
        offer_request(make_req(OP_LOAD_ACCEPT, 4'd15, 8'hFF, '0, 1'b1));
        offer_request(make_req(OP_LOAD_END, 4'd15, 8'h00, '1, 1'b0));
        offer_request(make_req(OP_LOAD_ACCEPT, 4'd0, 8'h7F, '0, 1'b0));
        offer_request(make_req(OP_MATCH, 4'd0, 8'h7F, '0, 1'b0));
        offer_request(make_req(OP_MATCH, 4'd0, LOWER_A, '0, 1'b0));
        offer_request(make_req(OP_MATCH, 4'd0, LOWER_A, '0, 1'b1));
        offer_request(make_req(OP_MATCH, 4'd0, LOWER_A, '0, 1'b1));

        // random subjects under several settings and idling patterns
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin fold = 1'b0; len = 5'd16; send_idle = 0;  recv_stall = 0;  end
                1: begin fold = 1'b1; len = 5'd16; send_idle = 87; recv_stall = 0;  end
                2: begin fold = 1'b0; len = 5'd1;  send_idle = 0;  recv_stall = 87; end
                3: begin fold = 1'b1; len = 5'd5;  send_idle = 31; recv_stall = 31; end
                4: begin fold = 1'b0; len = 5'd0;  send_idle = 0;  recv_stall = 0;  end
                5: begin fold = 1'b1; len = 5'd31; send_idle = 87; recv_stall = 0;  end
                6: begin fold = 1'b0; len = 5'd17; send_idle = 0;  recv_stall = 87; end
                default: begin fold = 1'b1; len = 5'd8; send_idle = 31; recv_stall = 31; end
            endcase
            wait_idle();
            write_config(fold, len);
            // long receiver hold-off while requests keep coming
            if (phase == 0) hold_left = HOLD_CYCLES;
            count  = 0;
            paused = 1'b0;
            while (count < PHASE_ITEMS) begin
                n_bytes = ($urandom_range(7) == 0) ? $urandom_range(13, 20) : $urandom_range(1, 8);
                for (int k = 0; k < n_bytes; k++) begin
                    roll = $urandom_range(99);
                    if (roll < 8) begin
                        offer_request(random_load());
                        count++;
                    end else if (roll < 10) begin
                        offer_request(make_req(OP_RESERVED, 4'($urandom_range(15)),
                                               8'($urandom_range(255)), {$urandom, $urandom},
                                               1'($urandom_range(1))));
                    end
                    offer_request(make_req(OP_MATCH, 4'($urandom_range(15)), pick_subject_byte(),
                                           {$urandom, $urandom}, k == n_bytes - 1));
                    count++;
                end
                // sender pause until the block has drained
                if (phase == 3 && !paused && count >= PHASE_ITEMS / 2) begin
                    wait_idle();
                    paused = 1'b1;
                end
            end
        end

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: multi_pattern_anchored_matcher.f
+incdir+design
design/mpam_pkg.sv
design/mpam_eval.sv
design/multi_pattern_anchored_matcher.sv
sim/mpam_checker.sv
sim/tb.sv
